/* src/u8dec_pkg.sv */
// Shared types and constants for the UTF-8 to UCS-2 decoder.
package u8dec_pkg;

   // Default number of decoded groups held between the front and back parts.
   localparam int QUEUE_DEPTH = 4;

   // Most code units that one input byte can release.
   localparam int MAX_UNITS = 3;

   typedef enum logic [1:0] {
      KIND_RAW   = 2'd0,
      KIND_TWO   = 2'd1,
      KIND_THREE = 2'd2
   } unit_kind_type;

   typedef struct packed {
      logic [15:0]   code;
      unit_kind_type kind;
   } unit_type;

   // All code units released by one accepted byte, oldest in slot 0.
   typedef struct packed {
      logic [1:0]                   count;
      logic                         last;
      unit_type [MAX_UNITS-1:0]     units;
   } group_type;

endpackage

/* src/u8dec_front.sv */
// Front part: holds pending bytes and splits each byte's window into code units.
module u8dec_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_in_last,
   input  logic                 push_ready,
   output logic                 push_valid,
   output u8dec_pkg::group_type push_group
);

   logic [7:0] pend_byte_ff [2];
   logic [7:0] pend_byte_in [2];
   logic [1:0] pend_count_ff;
   logic [1:0] pend_count_in;
   logic       accept;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   function automatic logic is_follow(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   always_comb begin
      logic [7:0]               win [3];
      logic [1:0]               have;
      logic [1:0]               cnt;
      logic                     stop;
      logic                     hold;
      logic [7:0]               h;
      logic [1:0]               used;
      logic [15:0]              unit;
      u8dec_pkg::unit_kind_type kind;
      u8dec_pkg::group_type     grp;

      win[0] = pend_byte_ff[0];
      win[1] = pend_byte_ff[1];
      win[2] = 8'h00;
      win[pend_count_ff] = req_in_byte;
      have = pend_count_ff + 2'd1;
      cnt  = 2'd0;
      stop = 1'b0;
      grp  = '0;

      // The window holds at most three bytes, so three passes cover every case.
      for (int s = 0; s < u8dec_pkg::MAX_UNITS; s++) begin
         h    = win[0];
         used = 2'd1;
         kind = u8dec_pkg::KIND_RAW;
         unit = {8'h00, h};
         hold = 1'b0;
         if (!stop && have != 2'd0) begin
            if (h[7:4] == 4'hE) begin
               if (have < 2'd2) begin
                  hold = !req_in_last;
               end else if (is_follow(win[1])) begin
                  if (have < 2'd3) begin
                     hold = !req_in_last;
                  end else if (is_follow(win[2])) begin
                     unit = {h[3:0], win[1][5:0], win[2][5:0]};
                     kind = u8dec_pkg::KIND_THREE;
                     used = 2'd3;
                  end
               end
            end else if (h[7:5] == 3'b110) begin
               if (have < 2'd2) begin
                  hold = !req_in_last;
               end else if (is_follow(win[1])) begin
                  unit = {5'b00000, h[4:0], win[1][5:0]};
                  kind = u8dec_pkg::KIND_TWO;
                  used = 2'd2;
               end
            end

            if (hold) begin
               stop = 1'b1;
            end else begin
               grp.units[cnt].code = unit;
               grp.units[cnt].kind = kind;
               cnt = cnt + 2'd1;
               if (used == 2'd1) begin
                  win[0] = win[1];
                  win[1] = win[2];
               end else if (used == 2'd2) begin
                  win[0] = win[2];
               end
               have = have - used;
            end
         end
      end

      grp.count  = cnt;
      grp.last   = req_in_last;
      push_group = grp;
      push_valid = req_valid && (cnt != 2'd0);

      if (req_in_last) begin
         pend_count_in   = 2'd0;
         pend_byte_in[0] = 8'h00;
         pend_byte_in[1] = 8'h00;
      end else begin
         pend_count_in   = have;
         pend_byte_in[0] = (have > 2'd0) ? win[0] : 8'h00;
         pend_byte_in[1] = (have > 2'd1) ? win[1] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_count_ff   <= 2'd0;
         pend_byte_ff[0] <= 8'h00;
         pend_byte_ff[1] <= 8'h00;
      end else if (accept) begin
         pend_count_ff   <= pend_count_in;
         pend_byte_ff[0] <= pend_byte_in[0];
         pend_byte_ff[1] <= pend_byte_in[1];
      end
   end

   // At most two bytes can ever wait for followers.
   assert property (@(posedge clock) disable iff (reset) pend_count_ff != 2'd3)
      else $error("front holds more than two pending bytes");

endmodule

/* src/u8dec_queue.sv */
// Short queue of decoded groups between the front and back parts.
module u8dec_queue #(
   parameter int DEPTH = u8dec_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  u8dec_pkg::group_type push_group,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output u8dec_pkg::group_type pop_group
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   u8dec_pkg::group_type mem_ff [DEPTH];
   logic [PtrW-1:0]      wr_ptr_ff;
   logic [PtrW-1:0]      rd_ptr_ff;
   logic [CntW-1:0]      count_ff;
   logic                 do_push;
   logic                 do_pop;

   assign push_ready = count_ff != CntW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_group  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CntW'(DEPTH))
      else $error("queue fill level exceeds its depth");

endmodule

/* src/u8dec_back.sv */
// Back part: one unit per cycle unless stalled; numbers units, marks string end.
module u8dec_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  u8dec_pkg::group_type pop_group,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_code_unit,
   output logic [1:0]           rsp_unit_kind,
   output logic [15:0]          rsp_unit_index,
   output logic                 rsp_out_last
);

   logic [1:0]  sel_ff;
   logic [15:0] index_ff;
   logic        valid_ff;
   logic [15:0] code_ff;
   logic [1:0]  kind_ff;
   logic [15:0] uidx_ff;
   logic        last_ff;
   logic        load;
   logic        group_done;
   logic        unit_last;

   assign load       = pop_valid && (!valid_ff || rsp_ready);
   assign group_done = sel_ff == (pop_group.count - 2'd1);
   assign unit_last  = pop_group.last && group_done;
   assign pop_ready  = load && group_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 2'd0;
         index_ff <= 16'd0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            sel_ff   <= group_done ? 2'd0 : sel_ff + 2'd1;
            if (unit_last) begin
               index_ff <= 16'd0;
            end else if (index_ff != 16'hFFFF) begin
               index_ff <= index_ff + 16'd1;
            end
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= pop_group.units[sel_ff].code;
         kind_ff <= pop_group.units[sel_ff].kind;
         uidx_ff <= index_ff;
         last_ff <= unit_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_code_unit  = code_ff;
   assign rsp_unit_kind  = kind_ff;
   assign rsp_unit_index = uidx_ff;
   assign rsp_out_last   = last_ff;

   assert property (@(posedge clock) disable iff (reset) (load && unit_last) |=> index_ff == 16'd0)
      else $error("unit numbering did not restart after the string end");

   assert property (@(posedge clock) disable iff (reset)
                    pop_valid |-> (pop_group.count != 2'd0 && sel_ff < pop_group.count))
      else $error("unit select runs past the head group");

endmodule

/* src/utf8_to_ucs2_decoder.sv */
// Top level of the streaming UTF-8 to UCS-2 decoder.
//
// The decoder takes one UTF-8 byte per item on the req_ channel, with req_in_last marking the
// final byte of a string, and delivers 16-bit UCS-2 code units on the rsp_ channel. A
// 1110xxxx lead followed by two 10xxxxxx bytes becomes one unit of kind 2, a 110xxxxx lead
// followed by one 10xxxxxx byte becomes one unit of kind 1, and every other byte, including a
// lead whose follower is wrong or missing at the end of the string, comes out raw and
// zero-extended as kind 0; bytes after a rejected lead are examined again. Each unit carries
// its position in the string, which saturates at 65535, and the final unit of a string has
// rsp_out_last set; numbering starts over for the next string. A byte is accepted every
// cycle while the group queue has room, so a byte stream runs at one byte per cycle. One byte
// can release zero to three units; the back end sends one unit per cycle while rsp_ready is
// high, so a byte that releases several units occupies the back end until all are sent, and
// the queue between front and back (QUEUE_DEPTH groups) absorbs such bursts and output
// stalls. A byte's units are stored in the queue and then registered at the back-end output.
module utf8_to_ucs2_decoder #(
   parameter int QUEUE_DEPTH = u8dec_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic [1:0]  rsp_unit_kind,
   output logic [15:0] rsp_unit_index,
   output logic        rsp_out_last
);

   // Front to queue: every byte that releases at least one unit pushes one group.
   logic                 push_valid;
   logic                 push_ready;
   u8dec_pkg::group_type push_group;

   // Queue to back: the back end pops a group once its last unit is loaded into the output register.
   logic                 pop_valid;
   logic                 pop_ready;
   u8dec_pkg::group_type pop_group;

   u8dec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .push_ready  (push_ready),
      .push_valid  (push_valid),
      .push_group  (push_group)
   );

   u8dec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_group (push_group),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_group  (pop_group)
   );

   u8dec_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_group      (pop_group),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_unit  (rsp_code_unit),
      .rsp_unit_kind  (rsp_unit_kind),
      .rsp_unit_index (rsp_unit_index),
      .rsp_out_last   (rsp_out_last)
   );

endmodule
